FILE: src/lighting_schedule_engine_assert.svh
`ifndef LIGHTING_SCHEDULE_ENGINE_ASSERT_SVH
`define LIGHTING_SCHEDULE_ENGINE_ASSERT_SVH

// Checks a condition in the same cycle as its trigger.
`define LSE_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lighting schedule engine assertion failed");

// Checks a condition in the cycle after its trigger.
`define LSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lighting schedule engine assertion failed");

`endif

FILE: src/lse_pkg.sv
package lse_pkg;

    localparam int CHANNELS               = 3;
    localparam int MAX_LEN                = 48;
    localparam int FIRST_CHANNEL_ENDPOINT = 11;
    localparam int MINUTES_PER_DAY        = 1440;

    localparam int MARKS     = MAX_LEN / 3;
    localparam int MEM_DEPTH = CHANNELS * MARKS;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MARK_W    = (MARKS > 1) ? $clog2(MARKS) : 1;
    localparam int MARKC_W   = $clog2(MARKS + 1);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MIN_W     = 11;

    localparam logic [1:0]  CMD_ATTR  = 2'd0;
    localparam logic [1:0]  CMD_SCHED = 2'd1;
    localparam logic [1:0]  CMD_TICK  = 2'd2;

    localparam logic [15:0] CLUSTER_MODE   = 16'hFF01;
    localparam logic [15:0] CLUSTER_LEVEL  = 16'h0008;
    localparam logic [15:0] ATTR_MODE      = 16'h0001;
    localparam logic [7:0]  MODE_ENDPOINT  = 8'd2;
    localparam logic [7:0]  MODE_SCHEDULED = 8'd1;
    localparam logic [7:0]  MODE_RESET     = 8'hFF;
    localparam logic [7:0]  LEN_RESET      = 8'((MAX_LEN < 36) ? MAX_LEN : 36);

    localparam logic [1:0]  LANE_LO  = 2'd0;
    localparam logic [1:0]  LANE_HI  = 2'd1;
    localparam logic [1:0]  LANE_LVL = 2'd2;

    typedef enum logic [2:0] {
        OP_MODE,
        OP_LEVEL,
        OP_LEN,
        OP_DATA,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [7:0]        endpoint;
        logic [7:0]        value;
        logic [CH_W-1:0]   ch;
        logic [MARK_W-1:0] mark;
        logic [1:0]        lane;
        logic [MIN_W-1:0]  minute;
    } job_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_SCAN,
        B_EMIT
    } bstate_t;

    // Exact floor(v / 3) for any 8-bit v.
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [16:0] p;
        p = 17'(v) * 17'd171;
        return p[16:9];
    endfunction

    function automatic logic [ADDR_W-1:0] mark_addr(input logic [CH_W-1:0] ch,
                                                    input logic [MARK_W-1:0] m);
        return ADDR_W'(int'(ch) * MARKS + int'(m));
    endfunction

endpackage

FILE: src/lse_front.sv
module lse_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [7:0]          s_endpoint,
    input  logic [15:0]         s_cluster,
    input  logic [15:0]         s_attribute,
    input  logic [7:0]          s_value,
    input  logic [7:0]          s_byte_index,
    input  logic [10:0]         s_current_minute,
    output logic                q_valid,
    input  logic                q_ready,
    output lse_pkg::job_t       q_job
);
    import lse_pkg::*;

    job_t       job;
    logic       keep;
    logic [7:0] ep_off;
    logic       is_chan;
    logic [7:0] offs;
    logic [7:0] quo;
    logic [7:0] rem;
    logic       push;
    logic       pop;

    job_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        ep_off  = s_endpoint - 8'(FIRST_CHANNEL_ENDPOINT);
        is_chan = (s_endpoint >= 8'(FIRST_CHANNEL_ENDPOINT)) && (ep_off < 8'(CHANNELS));
        offs    = s_byte_index - 8'd1;
        quo     = div3(offs);
        rem     = offs - quo - {quo[6:0], 1'b0};

        keep         = 1'b0;
        job.op       = OP_TICK;
        job.endpoint = s_endpoint;
        job.value    = s_value;
        job.ch       = ep_off[CH_W-1:0];
        job.mark     = quo[MARK_W-1:0];
        job.lane     = rem[1:0];
        job.minute   = (s_current_minute >= 11'(MINUTES_PER_DAY)) ?
                       s_current_minute - 11'(MINUTES_PER_DAY) : s_current_minute;

        unique case (s_command)
            CMD_ATTR: begin
                if (s_cluster == CLUSTER_MODE && s_endpoint == MODE_ENDPOINT &&
                    s_attribute == ATTR_MODE) begin
                    job.op = OP_MODE;
                    keep   = 1'b1;
                end else if (s_cluster == CLUSTER_LEVEL && s_endpoint > MODE_ENDPOINT) begin
                    job.op = OP_LEVEL;
                    keep   = 1'b1;
                end
            end
            CMD_SCHED: begin
                if (is_chan) begin
                    if (s_byte_index == 8'd0) begin
                        job.op    = OP_LEN;
                        job.value = (s_value > 8'(MAX_LEN)) ? 8'(MAX_LEN) : s_value;
                        keep      = 1'b1;
                    end else if (s_byte_index <= 8'(MAX_LEN) && quo < 8'(MARKS)) begin
                        job.op = OP_DATA;
                        keep   = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                job.op = OP_TICK;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && keep;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= job;
        end
    end

endmodule

FILE: src/lse_back.sv
`include "lighting_schedule_engine_assert.svh"

module lse_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  lse_pkg::job_t q_job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_channel_endpoint,
    output logic [7:0]    m_level,
    output logic          m_apply,
    output logic          m_last
);
    import lse_pkg::*;

    bstate_t            state_reg, state_next;
    logic [7:0]         mode_reg, mode_next;
    logic [7:0]         len_reg [CHANNELS];
    logic               len_we;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [MARKC_W-1:0] marks_reg, marks_next;
    logic [MARKC_W-1:0] issue_reg, issue_next;
    logic               rd_pend_reg;
    logic               found_reg, found_next;
    logic [MIN_W-1:0]   best_reg, best_next;
    logic [7:0]         lvl_reg, lvl_next;

    logic [7:0]         lo_mem  [MEM_DEPTH];
    logic [7:0]         hi_mem  [MEM_DEPTH];
    logic [7:0]         lvl_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_lo_reg, vld_hi_reg, vld_lvl_reg;
    logic [7:0]         rd_lo_reg, rd_hi_reg, rd_lvl_reg;
    logic               rd_vlo_reg, rd_vhi_reg, rd_vlvl_reg;

    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    logic [15:0]        mark_minute;
    logic [7:0]         mark_level;
    logic               mark_ok;
    logic [MIN_W-1:0]   mark_t;
    logic [MIN_W-1:0]   gap;

    logic               out_free;
    logic               load;
    logic               m_valid_reg;
    logic [7:0]         ep_reg, ep_next;
    logic [7:0]         level_reg, level_next;
    logic               apply_reg, apply_next;
    logic               last_reg, last_next;

    assign out_free = !m_valid_reg || m_ready;
    assign wr_addr  = mark_addr(q_job.ch, q_job.mark);
    assign rd_addr  = mark_addr(ch_reg, issue_reg[MARK_W-1:0]);

    // A never-written byte reads as zero, matching the cleared schedule.
    assign mark_minute = {rd_vhi_reg ? rd_hi_reg : 8'd0, rd_vlo_reg ? rd_lo_reg : 8'd0};
    assign mark_level  = rd_vlvl_reg ? rd_lvl_reg : 8'd0;
    assign mark_ok     = mark_minute < 16'(MINUTES_PER_DAY);
    assign mark_t      = mark_minute[MIN_W-1:0];
    assign gap         = (minute_reg >= mark_t) ? minute_reg - mark_t :
                         minute_reg + 11'(MINUTES_PER_DAY) - mark_t;

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        len_we      = 1'b0;
        ch_next     = ch_reg;
        minute_next = minute_reg;
        marks_next  = marks_reg;
        issue_next  = issue_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        lvl_next    = lvl_reg;
        q_ready     = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        load        = 1'b0;
        ep_next     = ep_reg;
        level_next  = level_reg;
        apply_next  = apply_reg;
        last_next   = last_reg;

        unique case (state_reg)
            B_IDLE: begin
                q_ready = out_free;
                if (q_valid && out_free) begin
                    unique case (q_job.op)
                        OP_MODE: mode_next = q_job.value;
                        OP_LEVEL: begin
                            load       = 1'b1;
                            ep_next    = q_job.endpoint;
                            level_next = q_job.value;
                            apply_next = 1'b1;
                            last_next  = 1'b1;
                        end
                        OP_LEN:  len_we = 1'b1;
                        OP_DATA: wr_en  = 1'b1;
                        OP_TICK: begin
                            if (mode_reg == MODE_SCHEDULED) begin
                                minute_next = q_job.minute;
                                ch_next     = '0;
                                state_next  = B_START;
                            end
                        end
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_START: begin
                marks_next = MARKC_W'(div3(len_reg[ch_reg]));
                issue_next = '0;
                found_next = 1'b0;
                best_next  = '0;
                lvl_next   = 8'd0;
                state_next = B_SCAN;
            end
            B_SCAN: begin
                if (issue_reg < marks_reg) begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + MARKC_W'(1);
                end
                if (rd_pend_reg && mark_ok && (!found_reg || gap < best_reg)) begin
                    found_next = 1'b1;
                    best_next  = gap;
                    lvl_next   = mark_level;
                end
                if (issue_reg >= marks_reg && !rd_pend_reg) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    ep_next    = 8'(FIRST_CHANNEL_ENDPOINT) + 8'(ch_reg);
                    level_next = found_reg ? lvl_reg : 8'd0;
                    apply_next = found_reg;
                    last_next  = (ch_reg == CH_W'(CHANNELS - 1));
                    if (ch_reg == CH_W'(CHANNELS - 1)) begin
                        state_next = B_IDLE;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = B_START;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            mode_reg    <= MODE_RESET;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                len_reg[c] <= LEN_RESET;
            end
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            rd_pend_reg <= rd_en;
            if (len_we) begin
                len_reg[q_job.ch] <= q_job.value;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        minute_reg <= minute_next;
        marks_reg  <= marks_next;
        issue_reg  <= issue_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        lvl_reg    <= lvl_next;
        ep_reg     <= ep_next;
        level_reg  <= level_next;
        apply_reg  <= apply_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_lo_reg  <= '0;
            vld_hi_reg  <= '0;
            vld_lvl_reg <= '0;
        end else if (wr_en) begin
            if (q_job.lane == LANE_LO) begin
                vld_lo_reg[wr_addr] <= 1'b1;
            end
            if (q_job.lane == LANE_HI) begin
                vld_hi_reg[wr_addr] <= 1'b1;
            end
            if (q_job.lane == LANE_LVL) begin
                vld_lvl_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && q_job.lane == LANE_LO) begin
            lo_mem[wr_addr] <= q_job.value;
        end
        if (wr_en && q_job.lane == LANE_HI) begin
            hi_mem[wr_addr] <= q_job.value;
        end
        if (wr_en && q_job.lane == LANE_LVL) begin
            lvl_mem[wr_addr] <= q_job.value;
        end
        if (rd_en) begin
            rd_lo_reg   <= lo_mem[rd_addr];
            rd_hi_reg   <= hi_mem[rd_addr];
            rd_lvl_reg  <= lvl_mem[rd_addr];
            rd_vlo_reg  <= vld_lo_reg[rd_addr];
            rd_vhi_reg  <= vld_hi_reg[rd_addr];
            rd_vlvl_reg <= vld_lvl_reg[rd_addr];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_channel_endpoint = ep_reg;
    assign m_level            = level_reg;
    assign m_apply            = apply_reg;
    assign m_last             = last_reg;

    `LSE_ASSERT(a_pop_only_idle, q_ready, state_reg == B_IDLE)
    `LSE_ASSERT(a_issue_bound, state_reg == B_SCAN, issue_reg <= marks_reg)
    `LSE_ASSERT_NEXT(a_read_in_scan, rd_en, state_reg == B_SCAN && rd_pend_reg)

endmodule

FILE: src/lighting_schedule_engine.sv
// Lighting schedule engine: keeps an operating mode and one schedule of time marks per light
// channel, and answers level requests and minute ticks with light level items. Incoming items
// are classified at the input and parked in a two-entry queue; attribute and schedule items
// are then carried out by the back end in its idle state. A minute tick in scheduled mode
// holds the back end through a start, scan and emit step for each channel in turn, the emit
// step waiting while the output register is stalled; the scan reads the mark store, which
// has one read port and delivers one mark per cycle. Level results and the per channel tick
// results go through a single output register.
module lighting_schedule_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_endpoint,
    input  logic [15:0] s_cluster,
    input  logic [15:0] s_attribute,
    input  logic [7:0]  s_value,
    input  logic [7:0]  s_byte_index,
    input  logic [10:0] s_current_minute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_channel_endpoint,
    output logic [7:0]  m_level,
    output logic        m_apply,
    output logic        m_last
);
    import lse_pkg::*;

    logic q_valid;
    logic q_ready;
    job_t q_job;

    lse_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_endpoint       (s_endpoint),
        .s_cluster        (s_cluster),
        .s_attribute      (s_attribute),
        .s_value          (s_value),
        .s_byte_index     (s_byte_index),
        .s_current_minute (s_current_minute),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_job            (q_job)
    );

    lse_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_job              (q_job),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_channel_endpoint (m_channel_endpoint),
        .m_level            (m_level),
        .m_apply            (m_apply),
        .m_last             (m_last)
    );

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lse_pkg::*;

    localparam logic [1:0]  CMD_UNUSED       = 2'd3;
    localparam logic [15:0] CLUSTER_SCHEDULE = 16'hFC01;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES     = 100;
    localparam int          REPORT_LIMIT     = 10;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_SINGLE
    } row_check_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  endpoint;
        logic [15:0] cluster;
        logic [15:0] attribute;
        logic [7:0]  value;
        logic [7:0]  byte_index;
        logic [10:0] current_minute;
    } command_item_t;

    typedef struct packed {
        logic [7:0] endpoint;
        logic [7:0] level;
        logic       apply;
        logic       last;
    } light_level_t;

    typedef struct packed {
        row_check_t    check;
        command_item_t item;
        light_level_t  level_out;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [7:0]  s_endpoint = '0;
    logic [15:0] s_cluster = '0;
    logic [15:0] s_attribute = '0;
    logic [7:0]  s_value = '0;
    logic [7:0]  s_byte_index = '0;
    logic [10:0] s_current_minute = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_channel_endpoint;
    logic [7:0]  m_level;
    logic        m_apply;
    logic        m_last;

    logic [7:0] mode_reg;
    logic [7:0] sched_len [CHANNELS];
    logic [7:0] sched_data [CHANNELS][MAX_LEN];

    light_level_t  pending_levels [$];
    light_level_t  fresh_levels [$];
    directed_row_t directed_rows [$];

    int sender_idle_pct = 0;
    int rcv_stall_pct = 0;
    int fail_count = 0;
    int items_accepted = 0;
    int tick_items = 0;
    int results_checked = 0;

    lighting_schedule_engine dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_endpoint         (s_endpoint),
        .s_cluster          (s_cluster),
        .s_attribute        (s_attribute),
        .s_value            (s_value),
        .s_byte_index       (s_byte_index),
        .s_current_minute   (s_current_minute),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_channel_endpoint (m_channel_endpoint),
        .m_level            (m_level),
        .m_apply            (m_apply),
        .m_last             (m_last)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin
        light_level_t exp_lvl;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_levels.size() == 0) begin
                note_failure($sformatf("unexpected result: ep %0d level %0d apply %0d last %0d",
                    m_channel_endpoint, m_level, m_apply, m_last));
            end else begin
                exp_lvl = pending_levels.pop_front();
                if (m_channel_endpoint !== exp_lvl.endpoint || m_level !== exp_lvl.level ||
                        m_apply !== exp_lvl.apply || m_last !== exp_lvl.last) begin
                    note_failure($sformatf(
                        "mismatch: expected ep %0d level %0d apply %0d last %0d, got ep %0d level %0d apply %0d last %0d",
                        exp_lvl.endpoint, exp_lvl.level, exp_lvl.apply, exp_lvl.last,
                        m_channel_endpoint, m_level, m_apply, m_last));
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired with %0d results outstanding.", pending_levels.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic predict_levels(input command_item_t it);
        int ch;
        int ep;
        int len;
        int marks;
        int t;
        int gap;
        int best;
        int now;
        logic found;
        logic [7:0] lvl;
        light_level_t r;
        fresh_levels.delete();
        ep = int'(it.endpoint);
        case (it.command)
            CMD_ATTR: begin
                if (it.cluster == CLUSTER_MODE) begin
                    if (it.endpoint == MODE_ENDPOINT && it.attribute == ATTR_MODE) begin
                        mode_reg = it.value;
                    end
                end else if (it.cluster == CLUSTER_LEVEL && it.endpoint > 8'd2) begin
                    r.endpoint = it.endpoint;
                    r.level = it.value;
                    r.apply = 1'b1;
                    r.last = 1'b1;
                    fresh_levels.push_back(r);
                end
            end
            CMD_SCHED: begin
                if (ep >= FIRST_CHANNEL_ENDPOINT && ep < FIRST_CHANNEL_ENDPOINT + CHANNELS) begin
                    ch = ep - FIRST_CHANNEL_ENDPOINT;
                    if (it.byte_index == 8'd0) begin
                        sched_len[ch] = (int'(it.value) > MAX_LEN) ? 8'(MAX_LEN) : it.value;
                    end else if (int'(it.byte_index) <= MAX_LEN) begin
                        sched_data[ch][int'(it.byte_index) - 1] = it.value;
                    end
                end
            end
            CMD_TICK: begin
                if (mode_reg == MODE_SCHEDULED) begin
                    now = int'(it.current_minute);
                    for (ch = 0; ch < CHANNELS; ch++) begin
                        len = int'(sched_len[ch]);
                        if (len > MAX_LEN) begin
                            len = MAX_LEN;
                        end
                        marks = len / 3;
                        best = 1 << 30;
                        found = 1'b0;
                        lvl = 8'd0;
                        for (int m = 0; m < marks; m++) begin
                            t = int'(sched_data[ch][3 * m]) |
                                (int'(sched_data[ch][3 * m + 1]) << 8);
                            if (t < MINUTES_PER_DAY) begin
                                gap = (now + MINUTES_PER_DAY - t) % MINUTES_PER_DAY;
                                if (gap < best) begin
                                    best = gap;
                                    lvl = sched_data[ch][3 * m + 2];
                                    found = 1'b1;
                                end
                            end
                        end
                        r.endpoint = 8'(FIRST_CHANNEL_ENDPOINT + ch);
                        r.level = found ? lvl : 8'd0;
                        r.apply = found;
                        r.last = (ch == CHANNELS - 1);
                        fresh_levels.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_command(input command_item_t it, input row_check_t chk,
                                input light_level_t typed_level);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_command <= it.command;
        s_endpoint <= it.endpoint;
        s_cluster <= it.cluster;
        s_attribute <= it.attribute;
        s_value <= it.value;
        s_byte_index <= it.byte_index;
        s_current_minute <= it.current_minute;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_accepted++;
        if (it.command == CMD_TICK) begin
            tick_items++;
        end
        predict_levels(it);
        if (chk == CHK_PREDICT) begin
            foreach (fresh_levels[i]) begin
                pending_levels.push_back(fresh_levels[i]);
            end
        end else if (chk == CHK_SINGLE) begin
            pending_levels.push_back(typed_level);
        end
    endtask

    task automatic wait_levels_drained();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic directed_row_t mk_row(input row_check_t chk, input logic [1:0] cmd,
            input logic [7:0] ep, input logic [15:0] cl, input logic [15:0] at,
            input logic [7:0] val, input logic [7:0] idx, input logic [10:0] minute,
            input logic [7:0] res_ep, input logic [7:0] res_lvl, input logic res_apply,
            input logic res_last);
        directed_row_t row;
        row.check = chk;
        row.item.command = cmd;
        row.item.endpoint = ep;
        row.item.cluster = cl;
        row.item.attribute = at;
        row.item.value = val;
        row.item.byte_index = idx;
        row.item.current_minute = minute;
        row.level_out.endpoint = res_ep;
        row.level_out.level = res_lvl;
        row.level_out.apply = res_apply;
        row.level_out.last = res_last;
        return row;
    endfunction

    function automatic command_item_t random_item();
        command_item_t it;
        it.command = 2'($urandom_range(3));
        it.endpoint = 8'($urandom);
        it.cluster = 16'($urandom);
        it.attribute = 16'($urandom);
        it.value = 8'($urandom);
        it.byte_index = 8'($urandom);
        it.current_minute = 11'($urandom);
        return it;
    endfunction

    task automatic run_random_phase(input int target);
        int start;
        int kind;
        int slot;
        logic [15:0] mark_minute;
        logic [7:0] mark_level;
        command_item_t it;
        start = items_accepted;
        while (items_accepted - start < target) begin
            kind = $urandom_range(99);
            it = random_item();
            if (kind < 30) begin
                slot = $urandom_range(MARKS - 1);
                mark_minute = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1440))
                                                       : 16'($urandom_range(1439));
                mark_level = 8'($urandom);
                it.command = CMD_SCHED;
                it.endpoint = 8'(FIRST_CHANNEL_ENDPOINT + $urandom_range(CHANNELS - 1));
                for (int k = 0; k < 3; k++) begin
                    it.byte_index = 8'(3 * slot + k + 1);
                    it.value = (k == 0) ? mark_minute[7:0] :
                               (k == 1) ? mark_minute[15:8] : mark_level;
                    send_command(it, CHK_PREDICT, '0);
                end
            end else if (kind < 45) begin
                it.command = CMD_SCHED;
                it.endpoint = 8'(FIRST_CHANNEL_ENDPOINT + $urandom_range(CHANNELS - 1));
                it.byte_index = 8'd0;
                case ($urandom_range(4))
                    0: it.value = 8'($urandom_range(2));
                    1: it.value = 8'($urandom);
                    default: it.value = 8'($urandom_range(MAX_LEN));
                endcase
                send_command(it, CHK_PREDICT, '0);
            end else if (kind < 65) begin
                it.command = CMD_TICK;
                it.current_minute = ($urandom_range(6) == 0) ? 11'($urandom_range(2047, 1440))
                                                             : 11'($urandom_range(1439));
                send_command(it, CHK_PREDICT, '0);
            end else if (kind < 75) begin
                it.command = CMD_ATTR;
                it.cluster = CLUSTER_LEVEL;
                if ($urandom_range(5) == 0) begin
                    it.endpoint = 8'($urandom_range(2));
                end
                send_command(it, CHK_PREDICT, '0);
            end else if (kind < 83) begin
                it.command = CMD_ATTR;
                it.cluster = CLUSTER_MODE;
                it.endpoint = MODE_ENDPOINT;
                it.attribute = ATTR_MODE;
                it.value = ($urandom_range(9) == 0) ? 8'($urandom) : MODE_SCHEDULED;
                send_command(it, CHK_PREDICT, '0);
            end else begin
                case ($urandom_range(3))
                    0: it.cluster = CLUSTER_MODE;
                    1: it.cluster = CLUSTER_LEVEL;
                    2: it.cluster = CLUSTER_SCHEDULE;
                    default: ;
                endcase
                if ($urandom_range(1) == 0) begin
                    it.attribute = ATTR_MODE;
                end
                send_command(it, CHK_PREDICT, '0);
            end
        end
    endtask

    initial begin
        directed_row_t row;
        mode_reg = MODE_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            sched_len[c] = LEN_RESET;
            for (int b = 0; b < MAX_LEN; b++) begin
                sched_data[c][b] = 8'd0;
            end
        end

        // The mode still holds its reset value, so the first tick must stay silent.
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0,
            11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SINGLE, CMD_ATTR, 8'd3, CLUSTER_LEVEL, 16'd0, 8'd0,
            8'd0, 11'd0, 8'd3, 8'd0, 1'b1, 1'b1));
        directed_rows.push_back(mk_row(CHK_SINGLE, CMD_ATTR, 8'd255, CLUSTER_LEVEL, 16'hFFFF,
            8'd255, 8'd255, 11'd2047, 8'd255, 8'd255, 1'b1, 1'b1));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, 8'd2, CLUSTER_LEVEL, 16'd0, 8'd7,
            8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, 8'd11, CLUSTER_SCHEDULE, ATTR_MODE,
            8'd9, 8'd1, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, MODE_ENDPOINT, CLUSTER_MODE,
            16'd2, MODE_SCHEDULED, 8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_UNUSED, 8'd255, 16'hFFFF, 16'hFFFF,
            8'd255, 8'd255, 11'd2047, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, MODE_ENDPOINT, CLUSTER_MODE,
            ATTR_MODE, MODE_SCHEDULED, 8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_PREDICT, CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0,
            11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'd255,
            8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'h9F,
            8'd1, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'h05,
            8'd2, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'd200,
            8'd3, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'hAA,
            8'd48, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd11, 16'd0, 16'd0, 8'h55,
            8'd49, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd10, 16'd0, 16'd0, 8'h77,
            8'd1, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd12, 16'd0, 16'd0, 8'd2,
            8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd13, 16'd0, 16'd0, 8'hA0,
            8'd1, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd13, 16'd0, 16'd0, 8'h05,
            8'd2, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_SCHED, 8'd13, 16'd0, 16'd0, 8'd3,
            8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_PREDICT, CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0,
            11'd1439, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_PREDICT, CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0,
            11'd2047, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, MODE_ENDPOINT, CLUSTER_MODE,
            ATTR_MODE, 8'd0, 8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0,
            11'd600, 8'd0, 8'd0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CHK_SILENT, CMD_ATTR, MODE_ENDPOINT, CLUSTER_MODE,
            ATTR_MODE, MODE_SCHEDULED, 8'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_command(row.item, row.check, row.level_out);
        end

        run_random_phase(40);
        wait_levels_drained();

        sender_idle_pct = 51;
        run_random_phase(40);

        sender_idle_pct = 0;
        rcv_stall_pct = 51;
        run_random_phase(40);
        wait_levels_drained();

        sender_idle_pct = 19;
        rcv_stall_pct = 19;
        run_random_phase(40);

        wait_levels_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Accepted %0d command items, %0d of them minute ticks, and checked %0d results",
            items_accepted, tick_items, results_checked);
        $display("across free-running, sender-idle, receiver-stall and mixed pacing; %0d failures.",
            fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
